### design/efr_pkg.sv
package efr_pkg;

  localparam int unsigned BufferDepthDef = 20;

  localparam logic [7:0] StartMarkerRst    = 8'd254;
  localparam logic [7:0] EndMarkerRst      = 8'd255;
  localparam logic [7:0] EscapeByteRst     = 8'd253;
  localparam logic [4:0] ExpectedLengthRst = 5'd13;
  localparam logic [9:0] TimeoutTicksRst   = 10'd50;

  localparam int unsigned CfgDataW = 10;
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_MARKER    = 3'd0,
    REG_END_MARKER      = 3'd1,
    REG_ESCAPE_BYTE     = 3'd2,
    REG_EXPECTED_LENGTH = 3'd3,
    REG_TIMEOUT_TICKS   = 3'd4
  } reg_idx_e;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_STATUS  = 2'd1,
    KIND_TIMEOUT = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_LENGTH   = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_DATA,
    S_STATUS,
    S_TOUT
  } state_e;

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] end_marker;
    logic [7:0] escape_byte;
    logic [4:0] expected_length;
    logic [9:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    status_e    status;
    logic       last;
  } result_t;

endpackage

### design/efr_store.sv
module efr_store #(
  parameter int unsigned BUFFER_DEPTH = efr_pkg::BufferDepthDef
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] waddr_i,
  input  logic [7:0]                      wdata_i,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] raddr_i,
  output logic [7:0]                      rdata_o
);

  logic [7:0] mem [BUFFER_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/efr_ctrl.sv
module efr_ctrl #(
  parameter int unsigned BUFFER_DEPTH = efr_pkg::BufferDepthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  efr_pkg::cfg_t                   cfg_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            operation_i,
  input  logic [7:0]                      rx_byte_i,
  input  logic                            out_free_i,
  output logic                            emit_o,
  output efr_pkg::result_t                res_o,
  output logic                            we_o,
  output logic [$clog2(BUFFER_DEPTH)-1:0] waddr_o,
  output logic [7:0]                      wdata_o,
  output logic [$clog2(BUFFER_DEPTH)-1:0] raddr_o,
  input  logic [7:0]                      rdata_i
);

  localparam int unsigned AW  = $clog2(BUFFER_DEPTH);
  localparam int unsigned CW  = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned CW1 = CW + 1;
  localparam int unsigned NW  = (CW > 5) ? CW : 5;

  efr_pkg::state_e state_q, state_d;
  logic          in_frame_q, in_frame_d;
  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic [9:0]    idle_q, idle_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [NW-1:0] n_q, n_d;
  logic [7:0]    acc_q, acc_d;
  logic          pair_q, pair_d;

  logic          is_start;
  logic          frm_open;
  logic [CW-1:0] cnt_base;
  logic          has_room;
  logic [CW-1:0] cnt_next;
  logic [7:0]    data_val;
  logic          more;

  assign is_start = (rx_byte_i == cfg_i.start_marker);
  assign frm_open = in_frame_q | is_start;
  assign cnt_base = is_start ? '0 : count_q;
  assign has_room = (cnt_base < CW'(BUFFER_DEPTH));
  assign cnt_next = (frm_open && has_room) ? cnt_base + CW'(1) : cnt_base;
  assign data_val = pair_q ? acc_q + rdata_i : rdata_i;
  assign more     = ((CW1'(idx_q) + CW1'(2)) < CW1'(count_q));

  assign waddr_o = AW'(cnt_base);
  assign wdata_o = rx_byte_i;
  assign raddr_o = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= efr_pkg::S_IDLE;
      in_frame_q <= 1'b0;
      count_q    <= '0;
      ovf_q      <= 1'b0;
      idle_q     <= '0;
      idx_q      <= '0;
      n_q        <= '0;
      acc_q      <= '0;
      pair_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      in_frame_q <= in_frame_d;
      count_q    <= count_d;
      ovf_q      <= ovf_d;
      idle_q     <= idle_d;
      idx_q      <= idx_d;
      n_q        <= n_d;
      acc_q      <= acc_d;
      pair_q     <= pair_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_frame_d = in_frame_q;
    count_d    = count_q;
    ovf_d      = ovf_q;
    idle_d     = idle_q;
    idx_d      = idx_q;
    n_d        = n_q;
    acc_d      = acc_q;
    pair_d     = pair_q;
    we_o       = 1'b0;
    emit_o     = 1'b0;
    res_o      = '{kind: efr_pkg::KIND_DATA, data: 8'd0, status: efr_pkg::ST_OK, last: 1'b0};
    in_stall_o = (state_q != efr_pkg::S_IDLE);

    case (state_q)
      efr_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (operation_i == efr_pkg::OP_TICK) begin
            if (idle_q >= cfg_i.timeout_ticks) begin
              idle_d  = '0;
              state_d = efr_pkg::S_TOUT;
            end else begin
              idle_d = idle_q + 10'd1;
            end
          end else begin
            idle_d     = '0;
            in_frame_d = frm_open;
            count_d    = cnt_next;
            ovf_d      = is_start ? 1'b0 : ovf_q;
            if (frm_open) begin
              if (has_room) begin
                we_o = 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            if (frm_open && (rx_byte_i == cfg_i.end_marker)) begin
              in_frame_d = 1'b0;
              idx_d      = AW'(1);
              n_d        = '0;
              pair_d     = 1'b0;
              state_d    = (CW'(2) < cnt_next) ? efr_pkg::S_ADDR : efr_pkg::S_STATUS;
            end
          end
        end
      end
      efr_pkg::S_ADDR: begin
        state_d = efr_pkg::S_DATA;
      end
      efr_pkg::S_DATA: begin
        if (!pair_q && (rdata_i == cfg_i.escape_byte)) begin
          acc_d   = rdata_i;
          pair_d  = 1'b1;
          idx_d   = idx_q + AW'(1);
          state_d = efr_pkg::S_ADDR;
        end else if (out_free_i) begin
          emit_o     = 1'b1;
          res_o.data = data_val;
          pair_d     = 1'b0;
          idx_d      = idx_q + AW'(1);
          n_d        = n_q + NW'(1);
          state_d    = more ? efr_pkg::S_ADDR : efr_pkg::S_STATUS;
        end
      end
      efr_pkg::S_STATUS: begin
        if (out_free_i) begin
          emit_o     = 1'b1;
          res_o.kind = efr_pkg::KIND_STATUS;
          res_o.last = 1'b1;
          if (ovf_q) begin
            res_o.status = efr_pkg::ST_OVERFLOW;
          end else if (n_q == NW'(cfg_i.expected_length)) begin
            res_o.status = efr_pkg::ST_OK;
          end else begin
            res_o.status = efr_pkg::ST_LENGTH;
          end
          state_d = efr_pkg::S_IDLE;
        end
      end
      efr_pkg::S_TOUT: begin
        if (out_free_i) begin
          emit_o     = 1'b1;
          res_o.kind = efr_pkg::KIND_TIMEOUT;
          res_o.last = 1'b1;
          state_d    = efr_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = efr_pkg::S_IDLE;
      end
    endcase
  end

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |-> out_free_i)
    else $error("result issued while output register busy");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o && res_o.last) |=> (state_q == efr_pkg::S_IDLE))
    else $error("sequencer busy after final result");

  a_read_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == efr_pkg::S_DATA) |-> (CW1'(idx_q) < CW1'(count_q)))
    else $error("store read beyond stored words");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(BUFFER_DEPTH))
    else $error("stored count beyond buffer depth");

endmodule

### design/escaped_frame_receiver_unit.sv
// Receives serial words (operation 0) and millisecond ticks (operation 1), one input
// word per handshake. A byte that causes no frame end, and a tick that causes no
// timeout, leave the block idle and ready for the next input word. A closing end
// marker starts a frame drain that reads the frame store (default depth 20) through
// its single registered read port: the address and data states per plain payload
// byte, both twice per escaped pair, the status state for the status word, plus any
// output stall; the input is stalled meanwhile, as in the timeout state. Results
// leave through an output register, so a finished result may wait while the next
// input word is taken. Configuration is written through cfg_we_i/cfg_idx_i/
// cfg_data_i; the user must do so only while the block is idle; it is not enforced.
module escaped_frame_receiver_unit #(
  parameter int unsigned BUFFER_DEPTH = efr_pkg::BufferDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [efr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [efr_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         operation_i,
  input  logic [7:0]                   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   kind_o,
  output logic [7:0]                   data_byte_o,
  output logic [1:0]                   status_o,
  output logic                         last_o
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);

  efr_pkg::cfg_t    cfg_q;
  efr_pkg::result_t out_q;
  efr_pkg::result_t res;
  logic             out_valid_q;
  logic             out_free;
  logic             emit;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [7:0]       wdata;
  logic [AW-1:0]    raddr;
  logic [7:0]       rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker    <= efr_pkg::StartMarkerRst;
      cfg_q.end_marker      <= efr_pkg::EndMarkerRst;
      cfg_q.escape_byte     <= efr_pkg::EscapeByteRst;
      cfg_q.expected_length <= efr_pkg::ExpectedLengthRst;
      cfg_q.timeout_ticks   <= efr_pkg::TimeoutTicksRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        efr_pkg::REG_START_MARKER:    cfg_q.start_marker    <= cfg_data_i[7:0];
        efr_pkg::REG_END_MARKER:      cfg_q.end_marker      <= cfg_data_i[7:0];
        efr_pkg::REG_ESCAPE_BYTE:     cfg_q.escape_byte     <= cfg_data_i[7:0];
        efr_pkg::REG_EXPECTED_LENGTH: cfg_q.expected_length <= cfg_data_i[4:0];
        efr_pkg::REG_TIMEOUT_TICKS:   cfg_q.timeout_ticks   <= cfg_data_i[9:0];
        default: begin
        end
      endcase
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  efr_ctrl #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .operation_i(operation_i),
    .rx_byte_i  (rx_byte_i),
    .out_free_i (out_free),
    .emit_o     (emit),
    .res_o      (res),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .raddr_o    (raddr),
    .rdata_i    (rdata)
  );

  efr_store #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_q.kind;
  assign data_byte_o = out_q.data;
  assign status_o    = out_q.status;
  assign last_o      = out_q.last;

endmodule

### bench/escaped_frame_receiver_unit_tb.sv
module escaped_frame_receiver_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import efr_pkg::*;

  localparam int SettleCycles = 60;
  localparam int HoldAtItem   = 200;
  localparam int HoldCycles   = 400;
  localparam int PhaseItems   = 64;
  localparam int NumPhases    = 6;

  typedef enum {ROW_BYTE, ROW_TICK, ROW_CFG} row_e;
  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_e;

  typedef struct {
    row_e       rk;
    reg_idx_e   idx;
    logic [9:0] val;
    int         reps;
    bit         typed;
    bit         one;
    kind_e      kind;
    status_e    st;
  } row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = REG_START_MARKER;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic                operation_i = OP_BYTE;
  logic [7:0]          rx_byte_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [1:0]          kind_o;
  logic [7:0]          data_byte_o;
  logic [1:0]          status_o;
  logic                last_o;

  escaped_frame_receiver_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .data_byte_o (data_byte_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the block: configuration and frame state
  logic [7:0]  c_start   = StartMarkerRst;
  logic [7:0]  c_end     = EndMarkerRst;
  logic [7:0]  c_escape  = EscapeByteRst;
  logic [4:0]  c_exp_len = ExpectedLengthRst;
  logic [9:0]  c_timeout = TimeoutTicksRst;
  bit          frame_open;
  bit          frame_ovf;
  int unsigned frame_cnt;
  logic [7:0]  frame_buf [BufferDepthDef];
  logic [9:0]  idle_cnt = '0;

  result_t     step_out[$];
  result_t     due_results[$];
  row_t        plan[$];
  int          fails      = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  bit          hold_req   = 1'b0;

  function automatic result_t res_of(kind_e k, logic [7:0] d, status_e s);
    result_t r;
    r.kind   = k;
    r.data   = d;
    r.status = s;
    r.last   = (k != KIND_DATA);
    return r;
  endfunction

  // results caused by one accepted input word
  task automatic decode_word(input op_e op, input logic [7:0] rx);
    int unsigned i;
    logic [7:0]  v;
    status_e     st;
    step_out.delete();
    if (op == OP_TICK) begin
      if (idle_cnt >= c_timeout) begin
        idle_cnt = '0;
        step_out.push_back(res_of(KIND_TIMEOUT, 8'h00, ST_OK));
      end else begin
        idle_cnt = idle_cnt + 10'd1;
      end
    end else begin
      idle_cnt = '0;
      if (rx == c_start) begin
        frame_open = 1'b1;
        frame_cnt  = 0;
        frame_ovf  = 1'b0;
      end
      if (frame_open) begin
        if (frame_cnt < BufferDepthDef) begin
          frame_buf[frame_cnt] = rx;
          frame_cnt++;
        end else begin
          frame_ovf = 1'b1;
        end
      end
      if (rx == c_end && frame_open) begin
        frame_open = 1'b0;
        i = 1;
        while (i + 1 < frame_cnt) begin
          v = frame_buf[i];
          if (v == c_escape) begin
            i++;
            v = v + frame_buf[i];
          end
          step_out.push_back(res_of(KIND_DATA, v, ST_OK));
          i++;
        end
        if (frame_ovf) st = ST_OVERFLOW;
        else if (step_out.size() == int'(c_exp_len)) st = ST_OK;
        else st = ST_LENGTH;
        step_out.push_back(res_of(KIND_STATUS, 8'h00, st));
      end
    end
  endtask

  task automatic send_word(input op_e op, input logic [7:0] rx, input bit typed = 1'b0,
                           input bit one = 1'b0, input kind_e kind = KIND_DATA,
                           input status_e st = ST_OK);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    operation_i <= op;
    rx_byte_i   <= rx;
    do @(posedge clk_i); while (in_stall_o);
    decode_word(op, rx);
    if (typed) begin
      if (one) due_results.push_back(res_of(kind, 8'h00, st));
    end else begin
      foreach (step_out[j]) due_results.push_back(step_out[j]);
    end
    items_sent++;
    if (items_sent == HoldAtItem) hold_req = 1'b1;
  endtask

  task automatic drain_all();
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [9:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_START_MARKER:    c_start   = val[7:0];
      REG_END_MARKER:      c_end     = val[7:0];
      REG_ESCAPE_BYTE:     c_escape  = val[7:0];
      REG_EXPECTED_LENGTH: c_exp_len = val[4:0];
      REG_TIMEOUT_TICKS:   c_timeout = val;
      default: ;
    endcase
  endtask

  function automatic logic [7:0] pick_byte(bit no_escape);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == c_start || b == c_end || (no_escape && b == c_escape));
    return b;
  endfunction

  task automatic send_frame();
    int units;
    units = $urandom_range(0, 1) ? int'(c_exp_len) : int'($urandom_range(0, 18));
    if ($urandom_range(0, 7) == 0) units += $urandom_range(8, 14);
    send_word(OP_BYTE, c_start);
    repeat (units) begin
      if ($urandom_range(0, 9) == 0) send_word(OP_TICK, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) == 0) begin
        send_word(OP_BYTE, c_escape);
        send_word(OP_BYTE, pick_byte(1'b0));
      end else begin
        send_word(OP_BYTE, pick_byte(1'b1));
      end
    end
    send_word(OP_BYTE, c_end);
  endtask

  // receiver: stall pattern of its own plus one long hold-off
  stall_e stall_mode = STALL_NONE;
  int     mode_left  = 0;
  int     hold_left  = 0;
  bit     hold_done  = 1'b0;

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_done   <= 1'b1;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_e'($urandom_range(0, 3));
        mode_left  <= $urandom_range(20, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
        default:     out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        $error("unexpected word: kind %0d data %0h status %0d last %0d",
               kind_o, data_byte_o, status_o, last_o);
        fails++;
      end else begin
        want = due_results.pop_front();
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind_o);
          fails++;
        end
        if (data_byte_o !== want.data) begin
          $error("data_byte: expected %0h, got %0h", want.data, data_byte_o);
          fails++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fails++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          fails++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int         phase_end;
    int         choice;
    logic [7:0] s;
    logic [7:0] e;
    logic [7:0] x;
    logic [4:0] len;
    logic [9:0] tout;

    //         kind      reg                  value   reps typed one   kind          status
    plan = '{
      '{ROW_BYTE, REG_START_MARKER,    10'h0FF, 1,  1'b1, 1'b0, KIND_DATA,    ST_OK},
      '{ROW_BYTE, REG_START_MARKER,    10'h000, 1,  1'b1, 1'b0, KIND_DATA,    ST_OK},
      '{ROW_TICK, REG_START_MARKER,    10'h000, 1,  1'b1, 1'b0, KIND_DATA,    ST_OK},
      '{ROW_BYTE, REG_START_MARKER,    10'h0FE, 1,  1'b0, 1'b0, KIND_DATA,    ST_OK},
      '{ROW_BYTE, REG_START_MARKER,    10'h001, 1,  1'b0, 1'b0, KIND_DATA,    ST_OK},
      '{ROW_BYTE, REG_START_MARKER,    10'h0FD, 1,  1'b0, 1'b0, KIND_DATA,    ST_OK},
      '{ROW_BYTE, REG_START_MARKER,    10'h003, 1,  1'b0, 1'b0, KIND_DATA,    ST_OK},
      '{ROW_BYTE, REG_START_MARKER,    10'h080, 1,  1'b0, 1'b0, KIND_DATA,    ST_OK},
      '{ROW_BYTE, REG_START_MARKER,    10'h0FF, 1,  1'b0, 1'b0, KIND_DATA,    ST_OK},
      // escape byte just before the end marker
      '{ROW_BYTE, REG_START_MARKER,    10'h0FE, 1,  1'b0, 1'b0, KIND_DATA,    ST_OK},
      '{ROW_BYTE, REG_START_MARKER,    10'h010, 1,  1'b0, 1'b0, KIND_DATA,    ST_OK},
      '{ROW_BYTE, REG_START_MARKER,    10'h0FD, 1,  1'b0, 1'b0, KIND_DATA,    ST_OK},
      '{ROW_BYTE, REG_START_MARKER,    10'h0FF, 1,  1'b0, 1'b0, KIND_DATA,    ST_OK},
      // restart inside a frame
      '{ROW_BYTE, REG_START_MARKER,    10'h0FE, 1,  1'b0, 1'b0, KIND_DATA,    ST_OK},
      '{ROW_BYTE, REG_START_MARKER,    10'h022, 1,  1'b0, 1'b0, KIND_DATA,    ST_OK},
      '{ROW_BYTE, REG_START_MARKER,    10'h0FE, 1,  1'b0, 1'b0, KIND_DATA,    ST_OK},
      '{ROW_BYTE, REG_START_MARKER,    10'h0FF, 1,  1'b1, 1'b1, KIND_STATUS,  ST_LENGTH},
      '{ROW_BYTE, REG_START_MARKER,    10'h0FE, 1,  1'b0, 1'b0, KIND_DATA,    ST_OK},
      '{ROW_BYTE, REG_START_MARKER,    10'h05A, 13, 1'b0, 1'b0, KIND_DATA,    ST_OK},
      '{ROW_BYTE, REG_START_MARKER,    10'h0FF, 1,  1'b0, 1'b0, KIND_DATA,    ST_OK},
      // store full
      '{ROW_BYTE, REG_START_MARKER,    10'h0FE, 1,  1'b0, 1'b0, KIND_DATA,    ST_OK},
      '{ROW_BYTE, REG_START_MARKER,    10'h041, 24, 1'b0, 1'b0, KIND_DATA,    ST_OK},
      '{ROW_BYTE, REG_START_MARKER,    10'h0FF, 1,  1'b0, 1'b0, KIND_DATA,    ST_OK},
      '{ROW_CFG,  REG_TIMEOUT_TICKS,   10'd1,   1,  1'b0, 1'b0, KIND_DATA,    ST_OK},
      '{ROW_TICK, REG_START_MARKER,    10'h000, 1,  1'b1, 1'b0, KIND_DATA,    ST_OK},
      '{ROW_TICK, REG_START_MARKER,    10'h0FF, 1,  1'b1, 1'b1, KIND_TIMEOUT, ST_OK},
      '{ROW_CFG,  REG_TIMEOUT_TICKS,   10'd0,   1,  1'b0, 1'b0, KIND_DATA,    ST_OK},
      '{ROW_TICK, REG_START_MARKER,    10'h000, 1,  1'b1, 1'b1, KIND_TIMEOUT, ST_OK},
      // start marker equal to end marker
      '{ROW_CFG,  REG_START_MARKER,    10'h000, 1,  1'b0, 1'b0, KIND_DATA,    ST_OK},
      '{ROW_CFG,  REG_END_MARKER,      10'h000, 1,  1'b0, 1'b0, KIND_DATA,    ST_OK},
      '{ROW_CFG,  REG_EXPECTED_LENGTH, 10'd0,   1,  1'b0, 1'b0, KIND_DATA,    ST_OK},
      '{ROW_BYTE, REG_START_MARKER,    10'h000, 1,  1'b1, 1'b1, KIND_STATUS,  ST_OK},
      '{ROW_CFG,  REG_EXPECTED_LENGTH, 10'd18,  1,  1'b0, 1'b0, KIND_DATA,    ST_OK},
      '{ROW_BYTE, REG_START_MARKER,    10'h000, 1,  1'b1, 1'b1, KIND_STATUS,  ST_LENGTH}
    };

    frame_open = 1'b0;
    frame_ovf  = 1'b0;
    frame_cnt  = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[k]) begin
      if (plan[k].rk == ROW_CFG) begin
        drain_all();
        write_reg(plan[k].idx, plan[k].val);
      end else begin
        repeat (plan[k].reps)
          send_word(op_e'((plan[k].rk == ROW_TICK) ? OP_TICK : OP_BYTE), plan[k].val[7:0],
                    plan[k].typed, plan[k].one, plan[k].kind, plan[k].st);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      drain_all();
      if (p == 0) begin
        s = 8'h00; e = 8'hFF; x = 8'h7F; len = 5'd0; tout = 10'd1;
      end else if (p == 1) begin
        s = 8'hFF; e = 8'h00; x = 8'h80; len = 5'd18; tout = 10'd1023;
      end else begin
        s = 8'($urandom_range(0, 255));
        do e = 8'($urandom_range(0, 255)); while (e == s);
        do x = 8'($urandom_range(0, 255)); while (x == s || x == e);
        len  = 5'($urandom_range(0, 18));
        tout = 10'($urandom_range(1, 12));
      end
      write_reg(REG_START_MARKER, {2'b00, s});
      write_reg(REG_END_MARKER, {2'b00, e});
      write_reg(REG_ESCAPE_BYTE, {2'b00, x});
      write_reg(REG_EXPECTED_LENGTH, {5'b00000, len});
      write_reg(REG_TIMEOUT_TICKS, tout);

      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end) begin
        choice = $urandom_range(0, 19);
        if (choice < 14) begin
          send_frame();
        end else if (choice < 16) begin
          repeat ($urandom_range(1, (c_timeout > 28) ? 30 : int'(c_timeout) + 2))
            send_word(OP_TICK, 8'($urandom_range(0, 255)));
        end else if (choice < 18) begin
          repeat ($urandom_range(1, 5)) send_word(OP_BYTE, 8'($urandom_range(0, 255)));
        end else if (choice == 18) begin
          // frame left open, the next start marker restarts it
          send_word(OP_BYTE, c_start);
          repeat ($urandom_range(0, 4)) send_word(OP_BYTE, pick_byte(1'b1));
        end else begin
          send_word(OP_BYTE, c_end);
        end
      end
    end

    drain_all();
    if (due_results.size() != 0) begin
      $error("%0d results never arrived", due_results.size());
      fails++;
    end
    if (fails == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
